@@ rtl/uart_command_line_responder_unit_assert.svh @@
// assertion macros shared by the responder rtl
`ifndef UART_COMMAND_LINE_RESPONDER_UNIT_ASSERT_SVH
`define UART_COMMAND_LINE_RESPONDER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define UCLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UCLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UCLR_ASSERT(lbl, prop, msg)
`define UCLR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/ucl_pkg.sv @@
// shared types, constants and message text of the command line responder
package ucl_pkg;

  // only the first bytes of a line take part in parsing
  localparam int unsigned PARSE_LEN = 5;
  localparam int unsigned CNT_W     = $clog2(PARSE_LEN + 1);
  localparam int unsigned IDX_W     = $clog2(PARSE_LEN);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned SAMPLE_W = 12;

  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_BANG  = 8'h21;
  localparam logic [7:0] CHR_QUERY = 8'h3F;
  localparam logic [7:0] CHR_EQUAL = 8'h3D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  localparam logic [23:0] NAME_CUR = "CUR";
  localparam logic [23:0] NAME_VLT = "VLT";
  localparam logic [23:0] NAME_STS = "STS";

  localparam logic [127:0] TXT_INVALID = "Invalid command\n";
  localparam logic [127:0] TXT_NOBANG  = "No '!' Detected\n";
  localparam logic [127:0] TXT_VCMD    = "Voltage Command\n";
  localparam logic [127:0] TXT_CREQ    = "Current Request\n";
  localparam logic [127:0] TXT_SREQ    = {8'h00, "Status Request\n"};
  localparam logic [127:0] TXT_VLT     = {88'h0, "!VLT="};

  // index of the first decimal digit in the voltage reply
  localparam logic [3:0] VLT_DIGIT0 = 4'd5;

  typedef enum logic [2:0] {
    M_INVALID,
    M_NOBANG,
    M_VCMD,
    M_CREQ,
    M_SREQ,
    M_VLT
  } msg_e;

  typedef struct packed {
    msg_e                  msg;
    logic                  then_inv;
    logic [SAMPLE_W-1:0]   sample;
  } desc_t;

  // index of the final byte of a message, digits included
  function automatic logic [3:0] msg_top(msg_e m);
    logic [3:0] t;
    unique case (m)
      M_SREQ:  t = 4'd14;
      M_VLT:   t = 4'd8;
      default: t = 4'd15;
    endcase
    return t;
  endfunction

  // fixed text byte of a message, first character at idx zero
  function automatic logic [7:0] msg_char(msg_e m, logic [3:0] idx);
    logic [127:0] txt;
    logic [3:0]   top;
    logic [3:0]   pos;
    unique case (m)
      M_NOBANG: begin txt = TXT_NOBANG; top = 4'd15; end
      M_VCMD:   begin txt = TXT_VCMD;   top = 4'd15; end
      M_CREQ:   begin txt = TXT_CREQ;   top = 4'd15; end
      M_SREQ:   begin txt = TXT_SREQ;   top = 4'd14; end
      M_VLT:    begin txt = TXT_VLT;    top = 4'd4;  end
      default:  begin txt = TXT_INVALID; top = 4'd15; end
    endcase
    pos = 4'(top - idx);
    return txt[{pos, 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/ucl_front.sv @@
// front end: line collection, sample capture and line classification
module ucl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic [ucl_pkg::SAMPLE_W-1:0]   adc_sample_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output ucl_pkg::desc_t                 desc_o
);

  logic [7:0]                   line_q [ucl_pkg::PARSE_LEN];
  logic [ucl_pkg::CNT_W-1:0]    cnt_q;
  logic [ucl_pkg::SAMPLE_W-1:0] sample_q;
  logic                         accept;
  logic                         is_term;
  logic                         name_cur;
  logic                         name_vlt;
  logic                         name_sts;
  logic                         is_req;
  logic                         type_ok;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_term    = !kind_i && (rx_byte_i == ucl_pkg::CHR_STAR || rx_byte_i == ucl_pkg::CHR_CR);
  assign push_o     = accept && is_term;

  assign name_cur = {line_q[1], line_q[2], line_q[3]} == ucl_pkg::NAME_CUR;
  assign name_vlt = {line_q[1], line_q[2], line_q[3]} == ucl_pkg::NAME_VLT;
  assign name_sts = {line_q[1], line_q[2], line_q[3]} == ucl_pkg::NAME_STS;
  assign is_req   = line_q[4] == ucl_pkg::CHR_QUERY;
  assign type_ok  = is_req || line_q[4] == ucl_pkg::CHR_EQUAL;

  always_comb begin
    desc_o.sample   = sample_q;
    desc_o.then_inv = 1'b0;
    desc_o.msg      = ucl_pkg::M_INVALID;
    if (line_q[0] != ucl_pkg::CHR_BANG) begin
      desc_o.msg = ucl_pkg::M_NOBANG;
    end else if (type_ok) begin
      case (line_q[1])
        "C": begin
          desc_o.msg      = ucl_pkg::M_CREQ;
          desc_o.then_inv = !name_cur;
        end
        "V": begin
          if (name_vlt) begin
            desc_o.msg = is_req ? ucl_pkg::M_VLT : ucl_pkg::M_VCMD;
          end
        end
        "S": begin
          desc_o.msg      = ucl_pkg::M_SREQ;
          desc_o.then_inv = !name_sts;
        end
        default: desc_o.msg = ucl_pkg::M_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sample_q <= '0;
      for (int i = 0; i < int'(ucl_pkg::PARSE_LEN); i++) begin
        line_q[i] <= '0;
      end
    end else if (accept) begin
      if (kind_i) begin
        sample_q <= adc_sample_i;
      end else if (is_term) begin
        cnt_q <= '0;
        for (int i = 0; i < int'(ucl_pkg::PARSE_LEN); i++) begin
          line_q[i] <= '0;
        end
      end else if (cnt_q < ucl_pkg::CNT_W'(ucl_pkg::PARSE_LEN)) begin
        // bytes past the parsed prefix never influence a reply
        line_q[cnt_q[ucl_pkg::IDX_W-1:0]] <= rx_byte_i;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  `include "uart_command_line_responder_unit_assert.svh"

  `UCLR_ASSERT(a_cnt_range, cnt_q <= ucl_pkg::CNT_W'(ucl_pkg::PARSE_LEN), "line count overrun")

endmodule

@@ rtl/ucl_fifo.sv @@
// two-entry descriptor queue between front and back
module ucl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucl_pkg::desc_t wdata_i,
  input  logic           pop_i,
  output ucl_pkg::desc_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  ucl_pkg::desc_t                 mem_q [ucl_pkg::FIFO_DEPTH];
  logic [ucl_pkg::FIFO_AW-1:0]    wr_q;
  logic [ucl_pkg::FIFO_AW-1:0]    rd_q;
  logic [ucl_pkg::FIFO_CW-1:0]    cnt_q;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = cnt_q == ucl_pkg::FIFO_CW'(ucl_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `include "uart_command_line_responder_unit_assert.svh"

  `UCLR_ASSERT(a_cnt_bound, cnt_q <= ucl_pkg::FIFO_CW'(ucl_pkg::FIFO_DEPTH), "queue count overflow")
  `UCLR_ASSERT(a_ptr_match, (empty_o || full_o) |-> (wr_q == rd_q), "queue pointers disagree with count")

endmodule

@@ rtl/ucl_back.sv @@
// back end: reply sequencer, decimal digits and output register
module ucl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fifo_empty_i,
  input  ucl_pkg::desc_t desc_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     tx_byte_o,
  output logic           last_o
);

  logic                         busy_q;
  ucl_pkg::msg_e                msg_q;
  logic                         then_inv_q;
  logic [3:0]                   idx_q;
  logic [ucl_pkg::SAMPLE_W-1:0] rem_q;
  logic                         out_valid_q;
  logic [7:0]                   tx_q;
  logic                         last_q;

  logic                         adv;
  logic                         is_digit;
  logic                         end_msg;
  logic [9:0]                   pwr;
  logic [3:0]                   digit;
  logic [13:0]                  dprod;
  logic [7:0]                   next_byte;

  assign adv      = !out_valid_q || !out_stall_i;
  assign pop_o    = !busy_q && !fifo_empty_i;
  assign is_digit = msg_q == ucl_pkg::M_VLT && idx_q >= ucl_pkg::VLT_DIGIT0;
  assign end_msg  = idx_q == ucl_pkg::msg_top(msg_q);

  always_comb begin
    case (idx_q)
      4'd5:    pwr = 10'd1000;
      4'd6:    pwr = 10'd100;
      4'd7:    pwr = 10'd10;
      default: pwr = 10'd1;
    endcase
  end

  // one decimal digit per emitted digit byte, picked by compares against multiples
  always_comb begin
    digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_q} >= 14'(k) * {4'b0000, pwr}) begin
        digit = 4'(k);
      end
    end
    dprod = {10'd0, digit} * {4'b0000, pwr};
  end

  assign next_byte = is_digit ? (ucl_pkg::CHR_ZERO + {4'b0000, digit})
                              : ucl_pkg::msg_char(msg_q, idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      msg_q       <= ucl_pkg::M_INVALID;
      then_inv_q  <= 1'b0;
      idx_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      tx_q        <= '0;
      last_q      <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= busy_q;
        if (busy_q) begin
          tx_q   <= next_byte;
          last_q <= end_msg && !then_inv_q;
          if (is_digit) begin
            rem_q <= rem_q - dprod[ucl_pkg::SAMPLE_W-1:0];
          end
          if (end_msg) begin
            if (then_inv_q) begin
              // mismatched name: fixed text is followed by the invalid message
              msg_q      <= ucl_pkg::M_INVALID;
              then_inv_q <= 1'b0;
              idx_q      <= '0;
            end else begin
              busy_q <= 1'b0;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
      end
      if (pop_o) begin
        busy_q     <= 1'b1;
        msg_q      <= desc_i.msg;
        then_inv_q <= desc_i.then_inv;
        rem_q      <= desc_i.sample;
        idx_q      <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign last_o      = last_q;

  `include "uart_command_line_responder_unit_assert.svh"

  `UCLR_ASSERT(a_idx_bound, busy_q |-> (idx_q <= ucl_pkg::msg_top(msg_q)), "reply index past message end")
  `UCLR_ASSERT(a_inv_src, (busy_q && then_inv_q) |-> (msg_q == ucl_pkg::M_CREQ || msg_q == ucl_pkg::M_SREQ), "trailing invalid text on wrong message")

endmodule

@@ rtl/uart_command_line_responder_unit.sv @@
// top level of the uart command line responder
//
// input channel (in_valid_i / in_stall_o): one word per item; kind_i = 0 carries a
// received character in rx_byte_i, kind_i = 1 a new converter reading in adc_sample_i.
// characters build a line; '*' or carriage return ends it and queues one reply.
// output channel (out_valid_o / out_stall_i): reply characters in tx_byte_o, one word
// each, last_o high on the final character of a reply (at most 32 characters).
// the first reply word passes the reply queue, the sequencer and the output register.
// input words are taken one per cycle while the two-entry reply queue has room; the
// reply sequencer sends one word per cycle while out_stall_i is low, and loads the
// next queue entry only once the current reply ends, leaving a gap between replies.
// the queue fills only when terminators outrun the sequencer; then in_stall_o rises.
// when the receiver stalls, the output word holds and the sequencer waits with it,
// while the front keeps collecting until the queue is full.
// reset: the line store, line count and latest sample clear to zero, the queue empties
// and no output word is valid.
module uart_command_line_responder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [ucl_pkg::SAMPLE_W-1:0] adc_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   tx_byte_o,
  output logic                         last_o
);

  logic           push;
  logic           pop;
  logic           fifo_full;
  logic           fifo_empty;
  ucl_pkg::desc_t wdesc;
  ucl_pkg::desc_t rdesc;

  ucl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .adc_sample_i (adc_sample_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .desc_o       (wdesc)
  );

  ucl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdesc),
    .pop_i   (pop),
    .rdata_o (rdesc),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  ucl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .desc_i       (rdesc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o)
  );

endmodule
